@@ rtl/ccl_pkg.sv @@
// Shared types, constants and codes of the chunk cache directory.
package ccl_pkg;

    localparam int SLOTS_DEFAULT = 64;
    localparam int CHUNK_EDGE    = 32;
    localparam int CHUNK_LAST    = 4;

    localparam int COORD_W   = 16;
    localparam int COORD_W4  = 8;
    localparam int EDGE_BITS = $clog2(CHUNK_EDGE);
    localparam int LAST_BITS = $clog2(CHUNK_LAST);
    localparam int CC_W      = COORD_W - EDGE_BITS;
    localparam int CW_W      = COORD_W4 - LAST_BITS;
    localparam int OFF_W     = 3 * EDGE_BITS + LAST_BITS;
    localparam int SLOT_OUT_W = 6;
    localparam int STAMP_W   = 64;

    localparam logic [1:0] KIND_READ  = 2'd0;
    localparam logic [1:0] KIND_WRITE = 2'd1;
    localparam logic [1:0] KIND_FLUSH = 2'd2;

    typedef struct packed {
        logic [1:0]          kind;
        logic [COORD_W-1:0]  coord_x;
        logic [COORD_W-1:0]  coord_y;
        logic [COORD_W-1:0]  coord_z;
        logic [COORD_W4-1:0] coord_w;
    } in_t;

    typedef struct packed {
        logic [CC_W-1:0] cx;
        logic [CC_W-1:0] cy;
        logic [CC_W-1:0] cz;
        logic [CW_W-1:0] cw;
    } tag_t;

    localparam int TAG_W = $bits(tag_t);

    typedef struct packed {
        logic                  hit;
        logic [SLOT_OUT_W-1:0] slot;
        logic [OFF_W-1:0]      offset;
        logic                  fetch_needed;
        logic                  writeback_needed;
        logic [CC_W-1:0]       victim_cx;
        logic [CC_W-1:0]       victim_cy;
        logic [CC_W-1:0]       victim_cz;
        logic [CW_W-1:0]       victim_cw;
        logic                  last;
    } out_t;

endpackage

@@ rtl/chunk_cache_lru_directory.sv @@
// Top level of the fully associative chunk cache directory with LRU replacement.
//
//  channel   direction  handshake               payload
//  command   in         start, busy             cmd (in_t)
//  result    out        strobe (one cycle)      result (out_t)
//
// A hit on the current slot is answered from the EVAL state, with no scan.
// Otherwise the tag and stamp memories are read one slot per cycle up to a
// hit or the last slot; a flush keeps busy high while it reads every slot,
// one result per dirty slot. Reset clears the valid and dirty flip-flops at
// once, so no clearing pass is needed. The receiver cannot stall; each result
// is shown for exactly one cycle.
module chunk_cache_lru_directory import ccl_pkg::*; #(
    parameter int SLOTS = SLOTS_DEFAULT
) (
    input  logic clk,
    input  logic rst_n,
    input  logic start,
    output logic busy,
    input  in_t  cmd,
    output logic strobe,
    output out_t result
);

    localparam int SLOT_W = $clog2(SLOTS);
    localparam logic [SLOT_W-1:0] LAST_IDX = SLOT_W'(SLOTS - 1);

    localparam logic [2:0] ST_IDLE  = 3'd0;
    localparam logic [2:0] ST_EVAL  = 3'd1;
    localparam logic [2:0] ST_SCAN  = 3'd2;
    localparam logic [2:0] ST_FIN   = 3'd3;
    localparam logic [2:0] ST_FLUSH = 3'd4;
    localparam logic [2:0] ST_FLEND = 3'd5;

    logic [2:0]         state_reg;
    logic [1:0]         kind_reg;
    tag_t               tag_reg;
    logic [OFF_W-1:0]   off_reg;
    logic [SLOTS-1:0]   valid_reg;
    logic [SLOTS-1:0]   dirty_reg;
    logic               cur_ok_reg;
    logic [SLOT_W-1:0]  cur_idx_reg;
    tag_t               cur_tag_reg;
    logic [STAMP_W-1:0] use_cnt_reg;
    logic [SLOT_W-1:0]  idx_reg;
    logic               found_reg;
    logic [SLOT_W-1:0]  found_idx_reg;
    logic               free_reg;
    logic [SLOT_W-1:0]  free_idx_reg;
    logic [SLOT_W-1:0]  min_idx_reg;
    logic [STAMP_W-1:0] min_stamp_reg;
    tag_t               min_tag_reg;
    logic               pend_reg;
    logic [SLOT_W-1:0]  pend_idx_reg;
    tag_t               pend_tag_reg;
    logic               strobe_reg;
    out_t               result_reg;

    tag_t               cmd_tag;
    logic [OFF_W-1:0]   cmd_off;
    logic [SLOT_W-1:0]  ram_addr;
    logic [SLOT_W-1:0]  victim_idx;
    logic               tag_we;
    logic               stamp_we;
    logic [TAG_W-1:0]   tag_rdata;
    logic [STAMP_W-1:0] stamp_rdata;
    tag_t               rd_tag;
    logic               scan_valid;
    logic               scan_match;
    logic               fast_hit;
    logic               victim_wb;

    function automatic logic [SLOT_OUT_W-1:0] slot_out(input logic [SLOT_W-1:0] s);
        logic [SLOT_W+SLOT_OUT_W-1:0] w;
        w = {{SLOT_OUT_W{1'b0}}, s};
        return w[SLOT_OUT_W-1:0];
    endfunction

    function automatic out_t make_result(input logic hit, input logic [SLOT_W-1:0] s,
                                         input logic [OFF_W-1:0] off, input logic fetch,
                                         input logic wb, input tag_t vt, input logic lst);
        out_t r;
        r.hit              = hit;
        r.slot             = slot_out(s);
        r.offset           = off;
        r.fetch_needed     = fetch;
        r.writeback_needed = wb;
        r.victim_cx        = vt.cx;
        r.victim_cy        = vt.cy;
        r.victim_cz        = vt.cz;
        r.victim_cw        = vt.cw;
        r.last             = lst;
        return r;
    endfunction

    ccl_coord u_coord (
        .cmd    (cmd),
        .tag    (cmd_tag),
        .offset (cmd_off)
    );

    ccl_ram #(.WIDTH(TAG_W), .DEPTH(SLOTS)) u_tag_ram (
        .clk   (clk),
        .we    (tag_we),
        .addr  (ram_addr),
        .wdata (tag_reg),
        .rdata (tag_rdata)
    );

    ccl_ram #(.WIDTH(STAMP_W), .DEPTH(SLOTS)) u_stamp_ram (
        .clk   (clk),
        .we    (stamp_we),
        .addr  (ram_addr),
        .wdata (use_cnt_reg),
        .rdata (stamp_rdata)
    );

    assign rd_tag     = tag_t'(tag_rdata);
    assign scan_valid = valid_reg[idx_reg];
    assign scan_match = scan_valid && (rd_tag == tag_reg);
    assign fast_hit   = cur_ok_reg && (cur_tag_reg == tag_reg);
    assign victim_idx = found_reg ? found_idx_reg : (free_reg ? free_idx_reg : min_idx_reg);
    assign victim_wb  = !free_reg && dirty_reg[min_idx_reg];
    assign tag_we     = (state_reg == ST_FIN) && !found_reg;
    assign stamp_we   = (state_reg == ST_FIN);

    always_comb
    begin
        case (state_reg)
            ST_SCAN, ST_FLUSH: ram_addr = idx_reg + SLOT_W'(1);
            ST_FIN:            ram_addr = victim_idx;
            default:           ram_addr = '0;
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg   <= ST_IDLE;
            valid_reg   <= '0;
            dirty_reg   <= '0;
            cur_ok_reg  <= 1'b0;
            use_cnt_reg <= STAMP_W'(1);
            found_reg   <= 1'b0;
            free_reg    <= 1'b0;
            pend_reg    <= 1'b0;
            strobe_reg  <= 1'b0;
        end
        else
        begin
            strobe_reg <= 1'b0;
            case (state_reg)
                ST_IDLE:
                begin
                    if (start)
                    begin
                        kind_reg  <= cmd.kind;
                        tag_reg   <= cmd_tag;
                        off_reg   <= cmd_off;
                        idx_reg   <= '0;
                        found_reg <= 1'b0;
                        free_reg  <= 1'b0;
                        pend_reg  <= 1'b0;
                        case (cmd.kind)
                            KIND_READ, KIND_WRITE: state_reg <= ST_EVAL;
                            KIND_FLUSH:            state_reg <= ST_FLUSH;
                            default:               state_reg <= ST_IDLE;
                        endcase
                    end
                end
                ST_EVAL:
                begin
                    if (fast_hit)
                    begin
                        if (kind_reg == KIND_WRITE)
                        begin
                            dirty_reg[cur_idx_reg] <= 1'b1;
                        end
                        strobe_reg <= 1'b1;
                        result_reg <= make_result(1'b1, cur_idx_reg, off_reg, 1'b0, 1'b0,
                                                  '0, 1'b1);
                        state_reg  <= ST_IDLE;
                    end
                    else
                    begin
                        state_reg <= ST_SCAN;
                    end
                end
                ST_SCAN:
                begin
                    if (scan_match)
                    begin
                        found_reg     <= 1'b1;
                        found_idx_reg <= idx_reg;
                        state_reg     <= ST_FIN;
                    end
                    else
                    begin
                        if (!scan_valid && !free_reg)
                        begin
                            free_reg     <= 1'b1;
                            free_idx_reg <= idx_reg;
                        end
                        if ((idx_reg == '0) || (stamp_rdata < min_stamp_reg))
                        begin
                            min_idx_reg   <= idx_reg;
                            min_stamp_reg <= stamp_rdata;
                            min_tag_reg   <= rd_tag;
                        end
                        if (idx_reg == LAST_IDX)
                        begin
                            state_reg <= ST_FIN;
                        end
                        else
                        begin
                            idx_reg <= idx_reg + SLOT_W'(1);
                        end
                    end
                end
                ST_FIN:
                begin
                    use_cnt_reg <= use_cnt_reg + STAMP_W'(1);
                    cur_ok_reg  <= 1'b1;
                    cur_idx_reg <= victim_idx;
                    cur_tag_reg <= tag_reg;
                    strobe_reg  <= 1'b1;
                    if (found_reg)
                    begin
                        if (kind_reg == KIND_WRITE)
                        begin
                            dirty_reg[found_idx_reg] <= 1'b1;
                        end
                        result_reg <= make_result(1'b1, found_idx_reg, off_reg, 1'b0, 1'b0,
                                                  '0, 1'b1);
                    end
                    else
                    begin
                        valid_reg[victim_idx] <= 1'b1;
                        dirty_reg[victim_idx] <= (kind_reg == KIND_WRITE);
                        result_reg <= make_result(1'b0, victim_idx, off_reg, 1'b1, victim_wb,
                                                  victim_wb ? min_tag_reg : '0, 1'b1);
                    end
                    state_reg <= ST_IDLE;
                end
                ST_FLUSH:
                begin
                    if (scan_valid && dirty_reg[idx_reg])
                    begin
                        dirty_reg[idx_reg] <= 1'b0;
                        if (pend_reg)
                        begin
                            strobe_reg <= 1'b1;
                            result_reg <= make_result(1'b0, pend_idx_reg, '0, 1'b0, 1'b1,
                                                      pend_tag_reg, 1'b0);
                        end
                        pend_reg     <= 1'b1;
                        pend_idx_reg <= idx_reg;
                        pend_tag_reg <= rd_tag;
                    end
                    if (idx_reg == LAST_IDX)
                    begin
                        state_reg <= ST_FLEND;
                    end
                    else
                    begin
                        idx_reg <= idx_reg + SLOT_W'(1);
                    end
                end
                ST_FLEND:
                begin
                    if (pend_reg)
                    begin
                        strobe_reg <= 1'b1;
                        result_reg <= make_result(1'b0, pend_idx_reg, '0, 1'b0, 1'b1,
                                                  pend_tag_reg, 1'b1);
                    end
                    pend_reg  <= 1'b0;
                    state_reg <= ST_IDLE;
                end
                default:
                begin
                    state_reg <= ST_IDLE;
                end
            endcase
        end
    end

    assign busy   = (state_reg != ST_IDLE);
    assign strobe = strobe_reg;
    assign result = result_reg;

endmodule

@@ rtl/ccl_ram.sv @@
// Generic single-port synchronous RAM with registered read data.
module ccl_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 16
) (
    input  logic                     clk,
    input  logic                     we,
    input  logic [$clog2(DEPTH)-1:0] addr,
    input  logic [WIDTH-1:0]         wdata,
    output logic [WIDTH-1:0]         rdata
);

    logic [WIDTH-1:0] mem [DEPTH];

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[addr] <= wdata;
        end
        rdata <= mem[addr];
    end

endmodule

@@ rtl/ccl_coord.sv @@
// Splits voxel coordinates into a chunk tag and an in-chunk element offset.
module ccl_coord import ccl_pkg::*; (
    input  in_t              cmd,
    output tag_t             tag,
    output logic [OFF_W-1:0] offset
);

    assign tag.cx = cmd.coord_x[COORD_W-1:EDGE_BITS];
    assign tag.cy = cmd.coord_y[COORD_W-1:EDGE_BITS];
    assign tag.cz = cmd.coord_z[COORD_W-1:EDGE_BITS];
    assign tag.cw = cmd.coord_w[COORD_W4-1:LAST_BITS];

    assign offset = {cmd.coord_x[EDGE_BITS-1:0], cmd.coord_y[EDGE_BITS-1:0],
                     cmd.coord_z[EDGE_BITS-1:0], cmd.coord_w[LAST_BITS-1:0]};

endmodule

@@ rtl/ccl_checker.sv @@
// Port-level assertions for the chunk cache directory, bound to its top level.
module ccl_checker import ccl_pkg::*; (
    input logic clk,
    input logic rst_n,
    input logic start,
    input logic busy,
    input in_t  cmd,
    input logic strobe,
    input out_t result
);

    a_access_busy: assert property (@(posedge clk) disable iff (!rst_n)
        start && !busy && (cmd.kind == KIND_READ || cmd.kind == KIND_WRITE)
        |=> busy && !strobe)
        else $error("access transfer did not start work");

    a_result_after_work: assert property (@(posedge clk) disable iff (!rst_n)
        strobe |-> $past(busy))
        else $error("result appeared without preceding work");

    a_flush_run_busy: assert property (@(posedge clk) disable iff (!rst_n)
        strobe && !result.last |-> busy)
        else $error("flush run ended before its final result");

    a_fetch_is_miss: assert property (@(posedge clk) disable iff (!rst_n)
        strobe && result.fetch_needed |-> !result.hit && result.last)
        else $error("fetch requested on a hit or inside a flush run");

endmodule

bind chunk_cache_lru_directory ccl_checker u_ccl_checker (.*);
